@@ rtl/mbet_pkg.sv @@
package mbet_pkg;

  // Coordinate format: signed, 28 fractional bits.
  localparam int unsigned CoordW  = 32;
  localparam int unsigned FracW   = 28;
  localparam int unsigned ProdW   = 2 * CoordW;
  // Width that holds every pre-saturation sum without overflow.
  localparam int unsigned SatW    = 48;
  localparam int unsigned ColW    = 12;
  localparam int unsigned RowW    = 12;
  localparam int unsigned CountW  = 16;
  localparam int unsigned HeightW = 13;
  // Folded row index, signed: image_height - 1 - row can go negative.
  localparam int unsigned IdxW    = 14;
  // A squared component below four fits in this many unsigned bits.
  localparam int unsigned SqW     = 30;
  localparam int unsigned CfgIdxW = 3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgRealStart = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgImagStart = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRealStep  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgImagStep  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgIterLimit = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgHeight    = 3'd5;

  // Magnitude bound of two in coordinate format.
  localparam logic signed [CoordW-1:0] TwoFix = CoordW'(2) <<< FracW;

  // Sequencer states of the escape-time unit.
  typedef enum logic [3:0] {
    SqIdle,
    SqMulCr,
    SqMulCi,
    SqLoad,
    SqCheck,
    SqSqImag,
    SqCross,
    SqUpdate,
    SqDone
  } mbet_state_e;

  // Saturate a wide signed sum to the coordinate range.
  function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [SatW-1:0] v);
    logic signed [SatW-1:0] hi;
    logic signed [SatW-1:0] lo;
    hi = SatW'($signed({1'b0, {(CoordW-1){1'b1}}}));
    lo = -hi - SatW'(1);
    if (v > hi) begin
      return hi[CoordW-1:0];
    end else if (v < lo) begin
      return lo[CoordW-1:0];
    end else begin
      return v[CoordW-1:0];
    end
  endfunction

endpackage

@@ rtl/mandelbrot_escape_time_unit.sv @@
// Escape-time unit: one pixel in, one iteration count out.
// The count is handed off when the point leaves the |z| < 2 box or reaches iteration_limit,
// or when |z|^2 >= 4 ends it. One 32x32 multiplier serves two setup products and three
// products per iteration. One pixel is in work at a time; the next pixel is taken while
// a count waits. Reset (rst_ni low, asynchronous) restores the default view and control.
module mandelbrot_escape_time_unit import mbet_pkg::*; #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write port.
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CoordW-1:0]  cfg_wdata_i,
  // Pixel input stream.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [23:0]        s_axis_tdata,  // [11:0] column, [23:12] row
  // Result output stream.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [15:0]        m_axis_tdata   // [15:0] iteration_count
);

  localparam logic [16:0] ColMax = 17'(MAX_DIM - 1);

  // Configuration registers.
  logic signed [CoordW-1:0] real_start_q, imag_start_q, real_step_q, imag_step_q;
  logic [CountW-1:0]        limit_q;
  logic [HeightW-1:0]       height_q;

  // Sequencer and datapath registers.
  mbet_state_e              state_q, state_d;
  logic [ColW-1:0]          col_q;
  logic signed [IdxW-1:0]   idx_q;
  logic signed [CoordW-1:0] cr_q, ci_q, zr_q, zi_q;
  logic signed [ProdW-1:0]  prod_q;
  logic [SqW-1:0]           r2_q;
  logic [CountW-1:0]        count_q;
  logic                     out_valid_q;
  logic [CountW-1:0]        res_q;

  // Input unpacking and row fold.
  logic [ColW-1:0]          in_col;
  logic [RowW-1:0]          in_row;
  logic [ColW-1:0]          col_clamped;
  logic signed [IdxW-1:0]   idx_fold;
  logic                     in_xfer;

  assign in_col      = s_axis_tdata[ColW-1:0];
  assign in_row      = s_axis_tdata[ColW+RowW-1:ColW];
  assign col_clamped = ({5'b0, in_col} > ColMax) ? ColMax[ColW-1:0] : in_col;
  assign idx_fold    = ({1'b0, in_row} >= {1'b0, height_q[HeightW-1:1]})
                     ? $signed({1'b0, height_q}) - IdxW'(1) - $signed({2'b0, in_row})
                     : $signed({2'b0, in_row});
  assign in_xfer     = s_axis_tvalid && s_axis_tready;

  // Shared multiplier operand selection.
  logic signed [CoordW-1:0] mul_a, mul_b;
  logic signed [ProdW-1:0]  mul_p;

  always_comb begin
    case (state_q)
      SqMulCr: begin
        mul_a = $signed({20'b0, col_q});
        mul_b = real_step_q;
      end
      SqMulCi: begin
        mul_a = CoordW'(idx_q);
        mul_b = imag_step_q;
      end
      SqCheck: begin
        mul_a = zr_q;
        mul_b = zr_q;
      end
      SqSqImag: begin
        mul_a = zi_q;
        mul_b = zi_q;
      end
      SqCross: begin
        mul_a = zr_q;
        mul_b = zi_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Escape tests and update arithmetic.
  logic                     out_of_box;
  logic                     at_limit;
  logic [SqW-1:0]           i2;
  logic [SqW:0]             mag2;
  logic                     mag_escape;
  logic signed [SatW-1:0]   cr_sum, ci_sum, zr_sum, zi_sum;
  logic signed [ProdW-1:0]  cross_sh;

  assign out_of_box = (zr_q >= TwoFix) || (zr_q <= -TwoFix) ||
                      (zi_q >= TwoFix) || (zi_q <= -TwoFix);
  assign at_limit   = (count_q == limit_q);
  assign i2         = prod_q[FracW+SqW-1:FracW];
  assign mag2       = {1'b0, r2_q} + {1'b0, i2};
  assign mag_escape = mag2[SqW];
  assign cr_sum     = SatW'(real_start_q) + prod_q[SatW-1:0];
  assign ci_sum     = SatW'(imag_start_q) + prod_q[SatW-1:0];
  assign zr_sum     = $signed({{(SatW-SqW){1'b0}}, r2_q}) - $signed({{(SatW-SqW){1'b0}}, i2})
                    + SatW'(cr_q);
  // Twice the cross product, floored back to the coordinate format.
  assign cross_sh   = prod_q >>> (FracW - 1);
  assign zi_sum     = cross_sh[SatW-1:0] + SatW'(ci_q);

  // Next-state logic.
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    case (state_q)
      SqIdle: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = SqMulCr;
        end
      end
      SqMulCr:  state_d = SqMulCi;
      SqMulCi:  state_d = SqLoad;
      SqLoad:   state_d = SqCheck;
      SqCheck: begin
        state_d = (at_limit || out_of_box) ? SqDone : SqSqImag;
      end
      SqSqImag: state_d = SqCross;
      SqCross: begin
        state_d = mag_escape ? SqDone : SqUpdate;
      end
      SqUpdate: state_d = SqCheck;
      SqDone: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = SqIdle;
        end
      end
      default: state_d = SqIdle;
    endcase
  end

  // State and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SqIdle;
      real_start_q <= -32'sd536870912;
      imag_start_q <= -32'sd402653184;
      real_step_q  <= 32'sd262144;
      imag_step_q  <= 32'sd196608;
      limit_q      <= 16'd256;
      height_q     <= 13'd1024;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgRealStart: real_start_q <= $signed(cfg_wdata_i);
          CfgImagStart: imag_start_q <= $signed(cfg_wdata_i);
          CfgRealStep:  real_step_q  <= $signed(cfg_wdata_i);
          CfgImagStep:  imag_step_q  <= $signed(cfg_wdata_i);
          CfgIterLimit: limit_q      <= cfg_wdata_i[CountW-1:0];
          CfgHeight:    height_q     <= cfg_wdata_i[HeightW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Result register: loaded when the sequencer hands off, cleared on transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == SqDone && (!out_valid_q || m_axis_tready)) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SqDone && (!out_valid_q || m_axis_tready)) begin
      res_q <= count_q;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    case (state_q)
      SqIdle: begin
        if (in_xfer) begin
          col_q   <= col_clamped;
          idx_q   <= idx_fold;
          count_q <= '0;
        end
      end
      SqMulCi: begin
        cr_q <= sat_coord(cr_sum);
      end
      SqLoad: begin
        ci_q <= sat_coord(ci_sum);
        zi_q <= sat_coord(ci_sum);
        zr_q <= cr_q;
      end
      SqSqImag: begin
        r2_q <= prod_q[FracW+SqW-1:FracW];
      end
      SqCross: begin
        // zr*zi is taken from the old zr this cycle.
        zr_q <= sat_coord(zr_sum);
      end
      SqUpdate: begin
        zi_q    <= sat_coord(zi_sum);
        count_q <= count_q + CountW'(1);
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q;

  // The count never runs past the limit while a pixel is in work.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SqIdle && state_q != SqMulCr) |-> (count_q <= limit_q))
    else $error("iteration count exceeded the limit");

  // No second pixel is taken in the cycle after a transfer.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while a pixel is in work");

  // The imaginary part is only squared while the real part lies inside the escape box.
  a_inside_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SqSqImag) |-> (zr_q < TwoFix && zr_q > -TwoFix))
    else $error("squaring started on an escaped point");

  // A new result only appears from the hand-off state.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == SqDone))
    else $error("result raised outside the hand-off state");

endmodule
